[sv/assert_macros.svh]
// Assertion macros used by shadow_edge_extruder_2d.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SEDE_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("invariant violated");
`define SEDE_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication violated");
`define SEDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");
`else
`define SEDE_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define SEDE_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define SEDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[sv/sede_pkg.sv]
package sede_pkg;
	localparam int COORD_W = 16;
	localparam int REG_IDX_W = 2;
	localparam int UNIT_W = 15;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LIGHT_X = 2'd0,
		REG_LIGHT_Y = 2'd1,
		REG_SHADOW_LEN = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		EX_IDLE,
		EX_SQX,
		EX_SQY,
		EX_ROOT,
		EX_LDX,
		EX_DIVX,
		EX_LDY,
		EX_DIVY,
		EX_PUSHX,
		EX_PUSHY
	} ext_state_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_EXS,
		T_EXE,
		T_OUT
	} top_state_t;

	typedef struct packed {
		logic start;
		coord_t px;
		coord_t py;
	} ext_req_t;

	typedef struct packed {
		logic done;
		coord_t ox;
		coord_t oy;
	} ext_rsp_t;
endpackage

[sv/sede_vtx_if.sv]
interface sede_vtx_if;
	import sede_pkg::*;
	logic valid;
	logic ready;
	coord_t vertex_x;
	coord_t vertex_y;
	logic last_vertex;
	modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
	modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

[sv/sede_res_if.sv]
interface sede_res_if;
	import sede_pkg::*;
	logic valid;
	logic ready;
	coord_t edge_start_x;
	coord_t edge_start_y;
	coord_t edge_end_x;
	coord_t edge_end_y;
	coord_t extrude_start_x;
	coord_t extrude_start_y;
	coord_t extrude_end_x;
	coord_t extrude_end_y;
	logic polygon_done;
	modport source (output valid, edge_start_x, edge_start_y, edge_end_x, edge_end_y,
		extrude_start_x, extrude_start_y, extrude_end_x, extrude_end_y, polygon_done,
		input ready);
	modport sink (input valid, edge_start_x, edge_start_y, edge_end_x, edge_end_y,
		extrude_start_x, extrude_start_y, extrude_end_x, extrude_end_y, polygon_done,
		output ready);
endinterface

[sv/sede_cfg_if.sv]
interface sede_cfg_if;
	import sede_pkg::*;
	logic valid;
	logic ready;
	logic [REG_IDX_W-1:0] reg_index;
	logic [COORD_W-1:0] wdata;
	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

[sv/sede_extrude.sv]
module sede_extrude (
	input logic clk,
	input logic arst_n,
	input sede_pkg::ext_req_t req,
	input sede_pkg::coord_t light_x,
	input sede_pkg::coord_t light_y,
	input logic [sede_pkg::COORD_W-1:0] shadow_len,
	output sede_pkg::ext_rsp_t rsp
);
	import sede_pkg::*;

	ext_state_t state_q, state_d;
	logic [4:0] cnt_q;
	logic nx_q, ny_q;
	logic [15:0] ax_q, ay_q;
	coord_t vx_q, vy_q, ox_q, oy_q;
	logic [32:0] sum_q;
	logic [63:0] n_q;
	logic [32:0] rem_q;
	logic [31:0] root_q;
	logic [32:0] r_q;
	logic [16:0] nb_q;
	logic [16:0] quo_q;
	logic [UNIT_W-1:0] ux_q, uy_q;
	logic done_q;

	logic signed [16:0] dx, dy;
	logic [16:0] adx, ady;
	logic [15:0] mul_a, mul_b;
	logic [31:0] prod;
	logic [34:0] rem_n, trial;
	logic [46:0] num;
	logic [32:0] r_n;
	logic [16:0] quo_n;
	logic [UNIT_W-1:0] unit_n;
	logic [31:0] off_sum;
	logic [16:0] off;
	logic signed [17:0] push_sum;
	coord_t push_sat;
	logic push_neg;
	coord_t push_v;

	assign dx = 17'(signed'({req.px[COORD_W-1], req.px})) -
		17'(signed'({light_x[COORD_W-1], light_x}));
	assign dy = 17'(signed'({req.py[COORD_W-1], req.py})) -
		17'(signed'({light_y[COORD_W-1], light_y}));
	assign adx = dx[16] ? 17'(-dx) : 17'(dx);
	assign ady = dy[16] ? 17'(-dy) : 17'(dy);

	always_comb begin
		case (state_q)
			EX_SQX: begin
				mul_a = ax_q;
				mul_b = ax_q;
			end
			EX_SQY: begin
				mul_a = ay_q;
				mul_b = ay_q;
			end
			EX_PUSHX: begin
				mul_a = shadow_len;
				mul_b = {1'b0, ux_q};
			end
			EX_PUSHY: begin
				mul_a = shadow_len;
				mul_b = {1'b0, uy_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign rem_n = {rem_q[32:0], n_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};

	assign num = {1'b0, (state_q == EX_LDX) ? ax_q : ay_q, 30'b0} + {16'b0, root_q[31:1]};
	assign r_n = {r_q[31:0], nb_q[16]};
	assign quo_n = {quo_q[15:0], (r_n >= {1'b0, root_q})};
	assign unit_n = (root_q == '0) ? '0 :
		(quo_n > 17'd32767) ? UNIT_W'(32767) : quo_n[UNIT_W-1:0];

	assign off_sum = prod + 32'd16384;
	assign off = off_sum[31:15];
	assign push_neg = (state_q == EX_PUSHX) ? nx_q : ny_q;
	assign push_v = (state_q == EX_PUSHX) ? vx_q : vy_q;
	assign push_sum = push_neg ?
		18'(signed'({{2{push_v[COORD_W-1]}}, push_v})) - 18'(signed'({1'b0, off})) :
		18'(signed'({{2{push_v[COORD_W-1]}}, push_v})) + 18'(signed'({1'b0, off}));
	always_comb begin
		if (push_sum[17:15] == 3'b000 || push_sum[17:15] == 3'b111) begin
			push_sat = push_sum[15:0];
		end else if (push_sum[17]) begin
			push_sat = coord_t'(16'sh8000);
		end else begin
			push_sat = coord_t'(16'sh7fff);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			EX_IDLE: if (req.start) state_d = EX_SQX;
			EX_SQX: state_d = EX_SQY;
			EX_SQY: state_d = EX_ROOT;
			EX_ROOT: if (cnt_q == '0) state_d = EX_LDX;
			EX_LDX: state_d = EX_DIVX;
			EX_DIVX: if (cnt_q == '0) state_d = EX_LDY;
			EX_LDY: state_d = EX_DIVY;
			EX_DIVY: if (cnt_q == '0) state_d = EX_PUSHX;
			EX_PUSHX: state_d = EX_PUSHY;
			EX_PUSHY: state_d = EX_IDLE;
			default: state_d = EX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == EX_PUSHY);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			EX_IDLE: begin
				vx_q <= req.px;
				vy_q <= req.py;
				nx_q <= dx[16];
				ny_q <= dy[16];
				ax_q <= adx[15:0];
				ay_q <= ady[15:0];
			end
			EX_SQX: sum_q <= {1'b0, prod};
			EX_SQY: begin
				n_q <= {1'b0, sum_q + {1'b0, prod}, 30'b0};
				rem_q <= '0;
				root_q <= '0;
				cnt_q <= 5'd31;
			end
			EX_ROOT: begin
				if (rem_n >= trial) begin
					rem_q <= 33'(rem_n - trial);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_n[32:0];
					root_q <= {root_q[30:0], 1'b0};
				end
				n_q <= {n_q[61:0], 2'b00};
				cnt_q <= cnt_q - 5'd1;
			end
			EX_LDX, EX_LDY: begin
				r_q <= {3'b0, num[46:17]};
				nb_q <= num[16:0];
				quo_q <= '0;
				cnt_q <= 5'd16;
			end
			EX_DIVX, EX_DIVY: begin
				r_q <= quo_n[0] ? 33'(r_n - {1'b0, root_q}) : r_n;
				nb_q <= {nb_q[15:0], 1'b0};
				quo_q <= quo_n;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					if (state_q == EX_DIVX) ux_q <= unit_n;
					else uy_q <= unit_n;
				end
			end
			EX_PUSHX: ox_q <= push_sat;
			EX_PUSHY: oy_q <= push_sat;
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.ox = ox_q;
	assign rsp.oy = oy_q;
endmodule

[sv/shadow_edge_extruder_2d.sv]
// Channel  Role   Payload
// vtx      sink   vertex_x, vertex_y, last_vertex
// res      source edge endpoints, extruded endpoints, polygon_done
// cfg      sink   reg_index, wdata (always ready)
// A vertex that opens a polygon, and is not also its last, is only stored. Each edge extrudes two
// endpoints in turn in the shared square-root and divide unit, each endpoint taking 32 root steps and
// two 17-step divisions; the last vertex of a longer polygon also computes the closing edge to the first.
// Vertices are not taken while an edge is computed or waits on res.
// Reset clears the light, length and polygon state at once.
`include "assert_macros.svh"
module shadow_edge_extruder_2d (
	input logic clk,
	input logic arst_n,
	sede_vtx_if.sink vtx,
	sede_res_if.source res,
	sede_cfg_if.sink cfg
);
	import sede_pkg::*;

	top_state_t state_q, state_d;
	coord_t light_x_q, light_y_q;
	logic [COORD_W-1:0] shadow_len_q;
	coord_t first_x_q, first_y_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic have_first_q, close_q;
	coord_t es_x_q, es_y_q, ee_x_q, ee_y_q;
	coord_t xs_x_q, xs_y_q, xe_x_q, xe_y_q;
	logic done_flag_q;
	logic go_q;
	logic vtx_xfer, res_xfer, edge_now;
	ext_req_t req;
	ext_rsp_t rsp;

	assign vtx_xfer = vtx.valid && vtx.ready;
	assign res_xfer = res.valid && res.ready;
	assign edge_now = have_first_q || vtx.last_vertex;

	always_comb begin
		state_d = state_q;
		vtx.ready = 1'b0;
		res.valid = 1'b0;
		case (state_q)
			T_IDLE: begin
				vtx.ready = 1'b1;
				if (vtx.valid && edge_now) state_d = T_EXS;
			end
			T_EXS: if (rsp.done) state_d = T_EXE;
			T_EXE: if (rsp.done) state_d = T_OUT;
			T_OUT: begin
				res.valid = 1'b1;
				if (res.ready) state_d = close_q ? T_EXS : T_IDLE;
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			go_q <= 1'b0;
			have_first_q <= 1'b0;
			close_q <= 1'b0;
			light_x_q <= '0;
			light_y_q <= '0;
			shadow_len_q <= '0;
		end else begin
			state_q <= state_d;
			go_q <= (state_d != state_q) && (state_d == T_EXS || state_d == T_EXE);
			if (cfg.valid) begin
				case (cfg.reg_index)
					REG_LIGHT_X: light_x_q <= cfg.wdata;
					REG_LIGHT_Y: light_y_q <= cfg.wdata;
					REG_SHADOW_LEN: shadow_len_q <= cfg.wdata;
					default: ;
				endcase
			end
			if (vtx_xfer) begin
				if (!have_first_q) begin
					have_first_q <= !vtx.last_vertex;
					close_q <= 1'b0;
				end else begin
					close_q <= vtx.last_vertex;
					if (vtx.last_vertex) have_first_q <= 1'b0;
				end
			end else if (res_xfer) begin
				close_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vtx_xfer) begin
			prev_x_q <= vtx.vertex_x;
			prev_y_q <= vtx.vertex_y;
			cur_x_q <= vtx.vertex_x;
			cur_y_q <= vtx.vertex_y;
			if (!have_first_q) begin
				first_x_q <= vtx.vertex_x;
				first_y_q <= vtx.vertex_y;
				es_x_q <= vtx.vertex_x;
				es_y_q <= vtx.vertex_y;
				ee_x_q <= vtx.vertex_x;
				ee_y_q <= vtx.vertex_y;
				done_flag_q <= 1'b1;
			end else begin
				es_x_q <= prev_x_q;
				es_y_q <= prev_y_q;
				ee_x_q <= vtx.vertex_x;
				ee_y_q <= vtx.vertex_y;
				done_flag_q <= 1'b0;
			end
		end else if (res_xfer && close_q) begin
			es_x_q <= cur_x_q;
			es_y_q <= cur_y_q;
			ee_x_q <= first_x_q;
			ee_y_q <= first_y_q;
			done_flag_q <= 1'b1;
		end
		if (state_q == T_EXS && rsp.done) begin
			xs_x_q <= rsp.ox;
			xs_y_q <= rsp.oy;
		end
		if (state_q == T_EXE && rsp.done) begin
			xe_x_q <= rsp.ox;
			xe_y_q <= rsp.oy;
		end
	end

	assign req.start = go_q;
	assign req.px = (state_q == T_EXE) ? ee_x_q : es_x_q;
	assign req.py = (state_q == T_EXE) ? ee_y_q : es_y_q;

	sede_extrude u_extrude (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.light_x(light_x_q),
		.light_y(light_y_q),
		.shadow_len(shadow_len_q),
		.rsp(rsp)
	);

	assign cfg.ready = 1'b1;
	assign res.edge_start_x = es_x_q;
	assign res.edge_start_y = es_y_q;
	assign res.edge_end_x = ee_x_q;
	assign res.edge_end_y = ee_y_q;
	assign res.extrude_start_x = xs_x_q;
	assign res.extrude_start_y = xs_y_q;
	assign res.extrude_end_x = xe_x_q;
	assign res.extrude_end_y = xe_y_q;
	assign res.polygon_done = done_flag_q;

	`SEDE_ASSERT_ALWAYS(a_one_side, clk, arst_n, !(vtx.ready && res.valid))
	`SEDE_ASSERT_IMPLIES(a_close_clears, clk, arst_n, res.valid && res.polygon_done, !have_first_q && !close_q)
	`SEDE_ASSERT_IMPLIES(a_done_busy, clk, arst_n, rsp.done, state_q == T_EXS || state_q == T_EXE)
	`SEDE_ASSERT_NEXT(a_edge_starts, clk, arst_n, vtx_xfer && edge_now, state_q == T_EXS && go_q)
endmodule

[tb/tb.sv]
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sede_pkg::*;

	typedef struct {
		coord_t sx, sy, ex, ey, xsx, xsy, xex, xey;
		logic done;
	} edge_t;

	typedef struct {
		coord_t x, y;
		logic last;
		logic chk;
		edge_t e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	sede_vtx_if vtx ();
	sede_res_if res ();
	sede_cfg_if cfg ();

	shadow_edge_extruder_2d i_dut (
		.clk(clk), .arst_n(arst_n), .vtx(vtx.sink), .res(res.source), .cfg(cfg.sink)
	);

	logic [15:0] lx, ly, slen;
	coord_t fx, fy, px, py;
	logic open_poly;
	edge_t pending_edges[$];
	logic literal_ok[$];
	edge_t literal_edges[$];
	int errors = 0;
	int cycles = 0;
	logic rx_on = 1'b1;

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic coord_t push(coord_t v, logic neg, longint unsigned u);
		longint unsigned off;
		longint r;
		off = (longint'(slen) * u + 16384) >> 15;
		r = neg ? longint'(v) - longint'(off) : longint'(v) + longint'(off);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return coord_t'(r);
	endfunction

	function automatic longint unsigned unit_len(longint unsigned a, longint unsigned s);
		longint unsigned q;
		if (s == 0) return 0;
		q = ((a << 30) + (s >> 1)) / s;
		return q > 32767 ? 64'd32767 : q;
	endfunction

	task automatic away_from_light(input coord_t vx, input coord_t vy,
			output coord_t ox, output coord_t oy);
		longint dx, dy;
		longint unsigned ax, ay, s;
		dx = longint'(vx) - longint'($signed(lx));
		dy = longint'(vy) - longint'($signed(ly));
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		while ((ax | ay) >= 65536) begin
			ax >>= 1;
			ay >>= 1;
		end
		s = isqrt((ax * ax + ay * ay) << 30);
		ox = push(vx, dx < 0, unit_len(ax, s));
		oy = push(vy, dy < 0, unit_len(ay, s));
	endtask

	task automatic predict_edge(coord_t sx, coord_t sy, coord_t ex, coord_t ey, logic d);
		edge_t e;
		e.sx = sx; e.sy = sy; e.ex = ex; e.ey = ey; e.done = d;
		away_from_light(sx, sy, e.xsx, e.xsy);
		away_from_light(ex, ey, e.xex, e.xey);
		pending_edges = {pending_edges, e};
	endtask

	task automatic predict_vertex(coord_t x, coord_t y, logic last);
		if (!open_poly) begin
			fx = x; fy = y; open_poly = 1'b1;
		end else begin
			predict_edge(px, py, x, y, 1'b0);
		end
		px = x; py = y;
		if (last) begin
			predict_edge(x, y, fx, fy, 1'b1);
			open_poly = 1'b0;
		end
	endtask

	function automatic int gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 2);
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wdata <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_LIGHT_X: lx = val;
			REG_LIGHT_Y: ly = val;
			REG_SHADOW_LEN: slen = val;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending_edges.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic send(coord_t x, coord_t y, logic last);
		int n;
		n = pending_edges.size();
		vtx.valid <= 1'b1;
		vtx.vertex_x <= x;
		vtx.vertex_y <= y;
		vtx.last_vertex <= last;
		@(posedge clk);
		while (!vtx.ready) @(posedge clk);
		predict_vertex(x, y, last);
		for (int k = n; k < pending_edges.size(); k++) literal_ok = {literal_ok, 1'b0};
		@(negedge clk);
		vtx.valid <= 1'b0;
		repeat (gap()) @(negedge clk);
	endtask

	function automatic logic same(edge_t a, edge_t b);
		return a.sx == b.sx && a.sy == b.sy && a.ex == b.ex && a.ey == b.ey &&
			a.xsx == b.xsx && a.xsy == b.xsy && a.xex == b.xex && a.xey == b.xey &&
			a.done == b.done;
	endfunction

	always @(posedge clk) begin
		edge_t got, want;
		logic lit;
		cycles <= cycles + 1;
		if (arst_n && res.valid && res.ready) begin
			got.sx = res.edge_start_x; got.sy = res.edge_start_y;
			got.ex = res.edge_end_x; got.ey = res.edge_end_y;
			got.xsx = res.extrude_start_x; got.xsy = res.extrude_start_y;
			got.xex = res.extrude_end_x; got.xey = res.extrude_end_y;
			got.done = res.polygon_done;
			if (pending_edges.size() == 0) begin
				errors++;
				$display("%0t: unexpected edge %p", $time, got);
			end else begin
				want = pending_edges.pop_front();
				lit = literal_ok.pop_front();
				if (lit) want = literal_edges.pop_front();
				if (!same(want, got)) begin
					errors++;
					$display("%0t: expected %p actual %p", $time, want, got);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!rx_on) res.ready <= 1'b0;
		else if ($urandom_range(0, 19) == 0) res.ready <= 1'b0;
		else if ($urandom_range(0, 3) == 0) res.ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (cycles > 3000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		edge_t z;
		coord_t vx, vy;
		int nv;
		vtx.valid = 1'b0; vtx.vertex_x = '0; vtx.vertex_y = '0; vtx.last_vertex = 1'b0;
		cfg.valid = 1'b0; cfg.reg_index = '0; cfg.wdata = '0;
		res.ready = 1'b0;
		lx = 0; ly = 0; slen = 0;
		fx = 0; fy = 0; px = 0; py = 0; open_poly = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// With reset registers the shadow length is zero, so no vertex is moved.
		z = '{16'sd5, -16'sd7, 16'sd5, -16'sd7, 16'sd5, -16'sd7, 16'sd5, -16'sd7, 1'b1};
		r = '{16'sd5, -16'sd7, 1'b1, 1'b1, z};
		rows = {rows, r};
		foreach (rows[i]) begin
			send(rows[i].x, rows[i].y, rows[i].last);
			if (rows[i].chk) begin
				literal_ok[$] = 1'b1;
				literal_edges = {literal_edges, rows[i].e};
			end
		end
		drain();
		rows.delete();
		write_reg(REG_SHADOW_LEN, 16'hffff);
		r = '{-16'sd32768, -16'sd32768, 1'b0, 1'b0, z};
		rows = {rows, r};
		r = '{16'sd32767, 16'sd32767, 1'b0, 1'b0, z};
		rows = {rows, r};
		r = '{16'sd32767, -16'sd32768, 1'b0, 1'b0, z};
		rows = {rows, r};
		r = '{16'sd0, 16'sd0, 1'b0, 1'b0, z};
		rows = {rows, r};
		r = '{-16'sd32768, 16'sd32767, 1'b1, 1'b0, z};
		rows = {rows, r};
		r = '{16'sd16, 16'sd0, 1'b1, 1'b0, z};
		rows = {rows, r};
		foreach (rows[i]) send(rows[i].x, rows[i].y, rows[i].last);
		drain();
		write_reg(REG_LIGHT_X, 16'h8000);
		write_reg(REG_LIGHT_Y, 16'h7fff);
		write_reg(REG_SHADOW_LEN, 16'h0100);
		foreach (rows[i]) send(rows[i].x, rows[i].y, rows[i].last);
		send(-16'sd32768, 16'sd32767, 1'b1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_LIGHT_X, ph == 0 ? 16'h7fff : 16'($urandom));
			write_reg(REG_LIGHT_Y, ph == 0 ? 16'h8000 : 16'($urandom));
			write_reg(REG_SHADOW_LEN, ph == 1 ? 16'h0000 : ph == 2 ? 16'hffff :
				16'($urandom_range(0, 4095)));
			for (int p = 0; p < 34; p++) begin
				nv = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
				for (int k = 0; k < nv; k++) begin
					vx = ($urandom_range(0, 7) == 0) ? coord_t'(lx) : coord_t'($urandom);
					vy = ($urandom_range(0, 7) == 0) ? coord_t'(ly) : coord_t'($urandom);
					if ($urandom_range(0, 1)) begin
						vx = coord_t'($signed(lx) + $signed(16'($urandom_range(0, 255) - 128)));
					end
					send(vx, vy, k == nv - 1);
				end
				if (p == 10) begin
					rx_on = 1'b0;
					repeat (300) @(negedge clk);
					rx_on = 1'b1;
				end
				if (p == 20) begin
					while (pending_edges.size() != 0) @(negedge clk);
				end
			end
			drain();
		end

		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
